[sv/bba_pkg.sv]
`default_nettype none

package bba_pkg;

  localparam int MAX_POOL_LOG2 = 32;
  localparam int MIN_POOL_LOG2 = 4;
  localparam int POOL_RESET    = 20;
  localparam int NUM_ORD       = MAX_POOL_LOG2 + 1;
  localparam int ORD_W         = 6;
  localparam int SIZE_W        = 33;
  localparam int ALIGN_W       = 16;
  localparam int ADDR_W        = 48;
  localparam int OFF_W         = 32;
  localparam int SUM_W         = SIZE_W + 1;

  typedef struct packed {
    logic [SIZE_W-1:0]  request_size;
    logic [ALIGN_W-1:0] alignment;
  } req_t;

  typedef struct packed {
    logic               status;
    logic [ADDR_W-1:0]  address;
    logic [SIZE_W-1:0]  granted_bytes;
  } res_t;

  typedef struct packed {
    logic [SIZE_W-1:0] granted;
    logic [ORD_W-1:0]  need;
  } job_t;

  localparam logic ST_GRANT = 1'b0;
  localparam logic ST_OOM   = 1'b1;

  // all bits at and below the highest set bit
  function automatic logic [ALIGN_W-1:0] smear16(input logic [ALIGN_W-1:0] a);
    logic [ALIGN_W-1:0] r;
    r = a;
    r = r | (r >> 1);
    r = r | (r >> 2);
    r = r | (r >> 4);
    r = r | (r >> 8);
    return r;
  endfunction

  // number of significant bits
  function automatic logic [ORD_W-1:0] bitlen(input logic [SUM_W-1:0] x);
    logic [ORD_W-1:0] n;
    n = '0;
    for (int k = 0; k < SUM_W; k++) begin
      if (x[k]) n = ORD_W'(k + 1);
    end
    return n;
  endfunction

  function automatic logic [ORD_W-1:0] lowest_set(input logic [NUM_ORD-1:0] c);
    logic [ORD_W-1:0] n;
    n = '0;
    for (int k = NUM_ORD - 1; k >= 0; k--) begin
      if (c[k]) n = ORD_W'(k);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

[sv/buddy_block_allocator_top.sv]
`default_nettype none

// A grant passes the front register, the queue and the back-end states FIND, READ and SPLIT,
//   which repeats once per order split (0..32); out of memory is reported from IDLE when the
//   request exceeds the pool, from FIND when no block is free. The split sequencer writes one
//   free half per cycle through the single offset memory port; the queue buffers new requests.
// done pulses for one cycle; the receiver cannot stall.
// Reset (rst, synchronous): pool 2^20 bytes, base 0, one whole free block.
module buddy_block_allocator_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire bba_pkg::req_t              req,
  output logic                            busy,
  output logic                            done,
  output bba_pkg::res_t                   result,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [3:0]                 paddr,
  input  wire logic [63:0]                pwdata,
  output logic [63:0]                     prdata,
  output logic                            pready
);
  import bba_pkg::*;

  localparam logic REG_POOL = 1'b0;
  localparam logic REG_BASE = 1'b1;

  logic [ORD_W-1:0]  pool;
  logic [ADDR_W-1:0] base;
  logic              wr;
  logic              init;
  logic [ORD_W-1:0]  pool_next;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  job_t f_job;
  job_t q_job;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign init   = wr && (paddr[3] == REG_POOL);

  always_comb begin
    if (pwdata[ORD_W-1:0] < ORD_W'(MIN_POOL_LOG2)) begin
      pool_next = ORD_W'(MIN_POOL_LOG2);
    end else if (pwdata[ORD_W-1:0] > ORD_W'(MAX_POOL_LOG2)) begin
      pool_next = ORD_W'(MAX_POOL_LOG2);
    end else begin
      pool_next = pwdata[ORD_W-1:0];
    end
  end

  always_comb begin
    case (paddr[3])
      REG_POOL: prdata = 64'(pool);
      default:  prdata = 64'(base);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool <= ORD_W'(POOL_RESET);
      base <= '0;
    end else if (wr) begin
      if (paddr[3] == REG_POOL) begin
        pool <= pool_next;
      end else if (paddr[3] == REG_BASE) begin
        base <= pwdata[ADDR_W-1:0];
      end
    end
  end

  bba_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .busy   (busy),
    .push   (q_push),
    .job    (f_job),
    .q_full (q_full)
  );

  bba_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_job (f_job),
    .full   (q_full),
    .pop    (q_pop),
    .rd_job (q_job),
    .empty  (q_empty)
  );

  bba_back u_back (
    .clk       (clk),
    .rst       (rst),
    .init      (init),
    .init_pool (pool_next),
    .pool      (pool),
    .base      (base),
    .q_empty   (q_empty),
    .q_job     (q_job),
    .pop       (q_pop),
    .done      (done),
    .result    (result)
  );

endmodule

`default_nettype wire

[sv/bba_front.sv]
`default_nettype none

module bba_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire bba_pkg::req_t req,
  output logic               busy,
  output logic               push,
  output bba_pkg::job_t      job,
  input  wire logic          q_full
);
  import bba_pkg::*;

  logic               fv;
  req_t               freq;
  logic [ALIGN_W-1:0] amask;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   aligned;
  logic               accept;

  assign busy   = fv && q_full;
  assign accept = start && !busy;
  assign push   = fv && !q_full;

  always_comb begin
    amask   = smear16(freq.alignment) >> 1;
    sum     = {1'b0, freq.request_size} + SUM_W'(amask);
    aligned = sum & ~SUM_W'(amask);
    job.granted = aligned[SIZE_W-1:0];
    job.need    = (aligned == '0) ? '0 : bitlen(aligned - SUM_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (accept) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      freq <= req;
    end
  end

endmodule

`default_nettype wire

[sv/bba_queue.sv]
`default_nettype none

module bba_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire bba_pkg::job_t wr_job,
  output logic               full,
  input  wire logic          pop,
  output bba_pkg::job_t      rd_job,
  output logic               empty
);
  import bba_pkg::*;

  job_t       slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign full   = (count == 2'd2);
  assign empty  = (count == 2'd0);
  assign rd_job = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= wr_job;
    end
  end

endmodule

`default_nettype wire

[sv/bba_back.sv]
`default_nettype none

module bba_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      init,
  input  wire logic [bba_pkg::ORD_W-1:0] init_pool,
  input  wire logic [bba_pkg::ORD_W-1:0] pool,
  input  wire logic [bba_pkg::ADDR_W-1:0] base,
  input  wire logic                      q_empty,
  input  wire bba_pkg::job_t             q_job,
  output logic                           pop,
  output logic                           done,
  output bba_pkg::res_t                  result
);
  import bba_pkg::*;

  typedef enum logic [1:0] {IDLE, FIND, READ, SPLIT} state_t;

  state_t             state;
  logic [NUM_ORD-1:0] order_free;
  logic [ORD_W-1:0]   need;
  logic [SIZE_W-1:0]  granted;
  logic [ORD_W-1:0]   i;
  logic [OFF_W-1:0]   off;

  logic [OFF_W-1:0]   off_mem [NUM_ORD];
  logic [OFF_W-1:0]   mem_q;
  logic               mem_we;
  logic [ORD_W-1:0]   mem_wa;
  logic [OFF_W-1:0]   mem_wd;

  logic [NUM_ORD-1:0] cand;
  logic [ORD_W-1:0]   found;
  logic [ORD_W-1:0]   im1;

  assign pop    = (state == IDLE) && !q_empty && !init;
  assign cand   = order_free & ~((NUM_ORD'(1) << need) - NUM_ORD'(1));
  assign found  = lowest_set(cand);
  assign im1    = i - ORD_W'(1);
  assign mem_we = (state == SPLIT) && (i != need);
  assign mem_wa = im1;
  assign mem_wd = off + (OFF_W'(1) << im1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      off_mem[mem_wa] <= mem_wd;
    end
    mem_q <= off_mem[found];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      order_free <= NUM_ORD'(1) << POOL_RESET;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (init) begin
            order_free <= NUM_ORD'(1) << init_pool;
          end else if (pop) begin
            need    <= q_job.need;
            granted <= q_job.granted;
            if (q_job.need > pool) begin
              done   <= 1'b1;
              result <= '{status: ST_OOM, address: '0, granted_bytes: '0};
            end else begin
              state <= FIND;
            end
          end
        end
        FIND: begin
          if (cand == '0) begin
            done   <= 1'b1;
            result <= '{status: ST_OOM, address: '0, granted_bytes: '0};
            state  <= IDLE;
          end else begin
            order_free[found] <= 1'b0;
            i                 <= found;
            state             <= READ;
          end
        end
        READ: begin
          // the pool-order block only comes from init, always at offset zero
          off   <= (i == pool) ? '0 : mem_q;
          state <= SPLIT;
        end
        SPLIT: begin
          if (i == need) begin
            done   <= 1'b1;
            result <= '{status: ST_GRANT, address: base + ADDR_W'(off),
                        granted_bytes: granted};
            state  <= IDLE;
          end else begin
            order_free[im1] <= 1'b1;
            i               <= im1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_no_free_above_pool: assert property (@(posedge clk) disable iff (rst)
    ((order_free >> pool) >> 1) == '0)
    else $error("free order above pool");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == IDLE))
    else $error("result strobe while an item is still in work");

  a_one_per_order: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !order_free[im1])
    else $error("split half lands on an order already free");

  a_oom_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_OOM) |-> (result.address == '0 && result.granted_bytes == '0))
    else $error("failed result carries data");
`endif

endmodule

`default_nettype wire

[test/bba_grant_checker.sv]
`timescale 1ns / 100ps

module bba_grant_checker #(
  parameter logic [3:0] POOL_ADDR = 4'h0,
  parameter logic [3:0] BASE_ADDR = 4'h8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic           busy,
  input  wire bba_pkg::req_t  req,
  input  wire logic           done,
  input  wire bba_pkg::res_t  result,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic           pready,
  input  wire logic [3:0]     paddr,
  input  wire logic [63:0]    pwdata,
  output int                  errors,
  output int                  pending
);
  import bba_pkg::*;

  logic [ORD_W-1:0]   pool_log2;
  logic [ADDR_W-1:0]  base;
  logic [NUM_ORD-1:0] free_map;
  logic [OFF_W-1:0]   free_off [NUM_ORD];
  res_t               grants_due [$];

  initial begin
    errors = 0;
    pending = 0;
  end

  task automatic reinit_pool();
    free_map = '0;
    foreach (free_off[o]) free_off[o] = '0;
    free_map[pool_log2] = 1'b1;
  endtask

  function automatic res_t allocate_block(input req_t r);
    logic [63:0] al;
    logic [63:0] aligned;
    logic [63:0] off;
    int need;
    int j;
    res_t g;
    al = 64'd1;
    for (int k = 0; k < ALIGN_W; k++) begin
      if (r.alignment[k]) al = 64'd1 << k;
    end
    aligned = (64'(r.request_size) + al - 64'd1) & ~(al - 64'd1);
    need = 0;
    while (need < 63 && (64'd1 << need) < aligned) need++;
    g = '0;
    g.status = ST_OOM;
    if (need > int'(pool_log2)) return g;
    j = need;
    while (j <= int'(pool_log2) && !free_map[j]) j++;
    if (j > int'(pool_log2)) return g;
    off = 64'(free_off[j]);
    free_map[j] = 1'b0;
    free_off[j] = '0;
    // split down: right half stays free one order lower
    for (int i = j; i > need; i--) begin
      free_map[i-1] = 1'b1;
      free_off[i-1] = OFF_W'(off + (64'd1 << (i - 1)));
    end
    g.status = ST_GRANT;
    g.address = ADDR_W'(64'(base) + off);
    g.granted_bytes = SIZE_W'(aligned);
    return g;
  endfunction

  task automatic flag(input string what, input logic [63:0] want, input logic [63:0] got);
    errors++;
    if (errors <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    res_t exp;
    if (rst) begin
      pool_log2 = ORD_W'(POOL_RESET);
      base = '0;
      reinit_pool();
      grants_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == POOL_ADDR) begin
          if (pwdata[5:0] < MIN_POOL_LOG2) pool_log2 = ORD_W'(MIN_POOL_LOG2);
          else if (pwdata[5:0] > MAX_POOL_LOG2) pool_log2 = ORD_W'(MAX_POOL_LOG2);
          else pool_log2 = pwdata[5:0];
          reinit_pool();
        end else if (paddr == BASE_ADDR) begin
          base = pwdata[ADDR_W-1:0];
        end
      end
      if (done) begin
        if (grants_due.size() == 0) begin
          flag("unexpected beat (address)", 64'd0, 64'(result.address));
        end else begin
          exp = grants_due.pop_front();
          if (result.status !== exp.status)
            flag("status", 64'(exp.status), 64'(result.status));
          if (result.address !== exp.address)
            flag("address", 64'(exp.address), 64'(result.address));
          if (result.granted_bytes !== exp.granted_bytes)
            flag("granted_bytes", 64'(exp.granted_bytes), 64'(result.granted_bytes));
        end
      end
      if (start && !busy) grants_due = {grants_due, allocate_block(req)};
    end
    pending = grants_due.size();
  end

endmodule

[test/tb_buddy_block_allocator_top.sv]
`timescale 1ns / 100ps

module tb_buddy_block_allocator_top;
  import bba_pkg::*;

  localparam logic [3:0] POOL_ADDR   = 4'h0;
  localparam logic [3:0] BASE_ADDR   = 4'h8;
  localparam int         ITEMS       = 450;
  localparam int         STALL_LIMIT = 3000;

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        start   = 1'b0;
  req_t        req     = '0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [63:0] pwdata  = '0;
  logic        busy;
  logic        done;
  res_t        result;
  logic [63:0] prdata;
  logic        pready;

  int errors;
  int pending;
  int sent    = 0;
  int plg     = POOL_RESET;
  bit no_idle = 1'b0;
  int quiet   = 0;

  buddy_block_allocator_top dut (
    .clk(clk), .rst(rst), .start(start), .req(req), .busy(busy), .done(done),
    .result(result), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  bba_grant_checker #(.POOL_ADDR(POOL_ADDR), .BASE_ADDR(BASE_ADDR)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .result(result), .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable && pwrite && pready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // start stays high after the beat so back-to-back requests need no re-raise
  task automatic issue(input logic [SIZE_W-1:0] size, input logic [ALIGN_W-1:0] align);
    int gap;
    bit free;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req <= '{request_size: size, alignment: align};
    do begin
      @(negedge clk);
      free = !busy;
      @(posedge clk);
    end while (!free);
    sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    @(posedge clk);
  endtask

  task automatic reg_write(input logic [3:0] addr, input logic [63:0] data);
    bit rdy;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = pready;
      @(posedge clk);
    end while (!rdy);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int k;
    int o;
    int v;
    int n;
    logic [63:0] raw;
    logic [SIZE_W-1:0] sz;
    logic [ALIGN_W-1:0] al;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset pool, base 0
    issue(33'd1, 16'd1);
    issue(33'd0, 16'd1);
    issue(33'd5, 16'd0);
    issue(33'd5, 16'd12);
    issue(33'd100, 16'h8000);
    issue(33'd3, 16'hffff);
    issue(33'h1_0000_0000, 16'd1);
    issue(33'h1_ffff_ffff, 16'h8000);
    issue(33'h0_0010_0000, 16'd1);
    settle();
    // largest pool, address wrap
    reg_write(POOL_ADDR, 64'd32);
    reg_write(BASE_ADDR, 64'h0000_ffff_ffff_ffff);
    issue(33'h1_0000_0000, 16'd1);
    issue(33'd1, 16'd1);
    settle();
    reg_write(POOL_ADDR, 64'd63);
    reg_write(BASE_ADDR, 64'h0000_ffff_ffff_fff0);
    issue(33'h0_8000_0000, 16'd1);
    issue(33'h0_8000_0000, 16'd1);
    issue(33'd1, 16'd1);
    settle();
    // smallest pool, below-range write
    reg_write(POOL_ADDR, 64'd0);
    reg_write(BASE_ADDR, 64'h0000_1234_5678_9abc);
    issue(33'd17, 16'd1);
    issue(33'd1, 16'd1);
    issue(33'd2, 16'd1);
    issue(33'd4, 16'd1);
    issue(33'd8, 16'd1);
    issue(33'd1, 16'd1);

    while (sent < ITEMS) begin
      settle();
      k = $urandom_range(0, 9);
      if (k == 0) v = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(33, 63);
      else if (k == 1) v = $urandom_range(0, 1) ? MIN_POOL_LOG2 : MAX_POOL_LOG2;
      else v = $urandom_range(MIN_POOL_LOG2, 24);
      plg = (v < MIN_POOL_LOG2) ? MIN_POOL_LOG2 : (v > MAX_POOL_LOG2) ? MAX_POOL_LOG2 : v;
      reg_write(POOL_ADDR, 64'(v));
      if ($urandom_range(0, 1)) begin
        raw = {$urandom, $urandom};
        k = $urandom_range(0, 3);
        if (k == 0) raw = '0;
        else if (k == 1) raw = 64'h0000_ffff_ffff_ffff - 64'($urandom_range(0, 255));
        reg_write(BASE_ADDR, {16'h0, raw[ADDR_W-1:0]});
      end
      no_idle = ($urandom_range(0, 3) == 0);
      n = $urandom_range(8, 30);
      repeat (n) begin
        raw = {$urandom, $urandom};
        k = $urandom_range(0, 9);
        if (k == 0) begin
          sz = raw[SIZE_W-1:0];
        end else begin
          if (k < 6) o = $urandom_range(0, plg / 2);
          else if (k < 9) o = $urandom_range(0, plg);
          else o = $urandom_range(0, 3);
          sz = SIZE_W'((raw & ((64'd1 << o) - 64'd1)) + 64'd1);
        end
        if ($urandom_range(0, 4) == 0) al = 16'($urandom);
        else al = 16'd1 << $urandom_range(0, 15);
        issue(sz, al);
      end
    end

    settle();
    repeat (40) @(posedge clk);
    @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[buddy_block_allocator_top.f]
sv/bba_pkg.sv
sv/bba_front.sv
sv/bba_queue.sv
sv/bba_back.sv
sv/buddy_block_allocator_top.sv
test/bba_grant_checker.sv
test/tb_buddy_block_allocator_top.sv
